// ===== rtl/assert_macros.svh =====
// assertion macros shared by the json string unescaper rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// shared types, character codes and helpers for the json string unescaper
// no dependencies
package jsu_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // parser mode
    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_HEX2 = 3'd3,
        MODE_HEX3 = 3'd4,
        MODE_HEX4 = 3'd5
    } mode_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_END     = 3'd1,
        ST_BAD_ESC = 3'd2,
        ST_CTRL    = 3'd3,
        ST_BAD_CP  = 3'd4,
        ST_UNTERM  = 3'd5,
        ST_BAD_HEX = 3'd6
    } status_t;

    // parser state carried between bytes
    typedef struct packed {
        mode_t       mode;
        logic [15:0] accum;
    } state_t;

    // up to three output beats caused by one input byte
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        status_t         status;
    } bundle_t;

    // hex digit value, bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

endpackage

// ===== rtl/jsu_skid.sv =====
// input register with skid entry for the json string unescaper
// depends on jsu_pkg and assert_macros.svh
`include "assert_macros.svh"
module jsu_skid (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       a_valid,
    output logic [7:0] a_byte,
    input  logic       a_take
);
    import jsu_pkg::*;

    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_byte_reg, a_byte_next;
    logic       s_valid_reg, s_valid_next;
    logic [7:0] s_byte_reg, s_byte_next;
    logic       accept;

    // stall comes straight from the skid flag
    assign in_stall = s_valid_reg;
    assign accept   = in_valid && !s_valid_reg;
    assign a_valid  = a_valid_reg;
    assign a_byte   = a_byte_reg;

    // refill the main entry from skid first, else from the port
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_byte_next  = a_byte_reg;
        s_valid_next = s_valid_reg;
        s_byte_next  = s_byte_reg;
        if (!a_valid_reg || a_take)
        begin
            if (s_valid_reg)
            begin
                a_valid_next = 1'b1;
                a_byte_next  = s_byte_reg;
                s_valid_next = 1'b0;
            end
            else
            begin
                a_valid_next = accept;
                a_byte_next  = in_byte;
            end
        end
        else if (accept)
        begin
            s_valid_next = 1'b1;
            s_byte_next  = in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_byte_reg <= a_byte_next;
        s_byte_reg <= s_byte_next;
    end

    // skid entry is only ever used behind a held main entry
    `ASSERT_CLK(a_skid_behind_main, !s_valid_reg || a_valid_reg, "skid full with main empty")

endmodule

// ===== rtl/jsu_decode.sv =====
// byte decoder: escape handling, hex accumulation and utf-8 encoding
// depends on jsu_pkg
module jsu_decode (
    input  logic [7:0]      in_byte,
    input  jsu_pkg::state_t state_cur,
    output jsu_pkg::state_t state_nxt,
    output jsu_pkg::bundle_t res
);
    import jsu_pkg::*;

    logic [4:0]  hex;
    logic [15:0] cp;

    assign hex = hex_value(in_byte);
    assign cp  = {state_cur.accum[11:0], hex[3:0]};

    always_comb
    begin
        state_nxt.mode  = MODE_TEXT;
        state_nxt.accum = '0;
        res.cnt    = 2'd1;
        res.bytes  = '0;
        res.status = ST_DATA;
        if (in_byte == 8'h00)
        begin
            res.status = ST_UNTERM;
        end
        else
        begin
            case (state_cur.mode)
                // after a backslash
                MODE_ESC:
                begin
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = in_byte;
                        CH_LOW_B: res.bytes[0] = CH_BS;
                        CH_LOW_F: res.bytes[0] = CH_FF;
                        CH_LOW_N: res.bytes[0] = CH_LF;
                        CH_LOW_R: res.bytes[0] = CH_CR;
                        CH_LOW_T: res.bytes[0] = CH_TAB;
                        CH_LOW_U:
                        begin
                            state_nxt.mode = MODE_HEX1;
                            res.cnt        = 2'd0;
                        end
                        default: res.status = ST_BAD_ESC;
                    endcase
                end
                // hex digits of a unicode escape
                MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
                begin
                    if (hex[4])
                    begin
                        res.status = ST_BAD_HEX;
                    end
                    else if (state_cur.mode != MODE_HEX4)
                    begin
                        state_nxt.mode  = mode_t'(state_cur.mode + 3'd1);
                        state_nxt.accum = cp;
                        res.cnt         = 2'd0;
                    end
                    else if (cp[15:11] == 5'b11011)
                    begin
                        res.status = ST_BAD_CP;
                    end
                    else if (cp[15:7] == '0)
                    begin
                        res.bytes[0] = cp[7:0];
                    end
                    else if (cp[15:11] == '0)
                    begin
                        res.cnt      = 2'd2;
                        res.bytes[0] = {3'b110, cp[10:6]};
                        res.bytes[1] = {2'b10, cp[5:0]};
                    end
                    else
                    begin
                        res.cnt      = 2'd3;
                        res.bytes[0] = {4'b1110, cp[15:12]};
                        res.bytes[1] = {2'b10, cp[11:6]};
                        res.bytes[2] = {2'b10, cp[5:0]};
                    end
                end
                // plain text, also the unreachable codes
                default:
                begin
                    if (in_byte == CH_QUOTE)
                        res.status = ST_END;
                    else if (in_byte == CH_BSLASH)
                    begin
                        state_nxt.mode = MODE_ESC;
                        res.cnt        = 2'd0;
                    end
                    else if (in_byte < CH_SPACE)
                        res.status = ST_CTRL;
                    else
                        res.bytes[0] = in_byte;
                end
            endcase
        end
    end

endmodule

// ===== rtl/jsu_emit.sv =====
// output shift register that sends a decoded bundle one beat per cycle while out_stall is low
// depends on jsu_pkg and assert_macros.svh
`include "assert_macros.svh"
module jsu_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jsu_pkg::bundle_t bundle,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic [2:0]       status,
    output logic             last
);
    import jsu_pkg::*;

    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0][7:0] bytes_reg, bytes_next;
    status_t         status_reg, status_next;
    logic            take;

    assign out_valid = (cnt_reg != 2'd0);
    assign take      = out_valid && !out_stall;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);
    assign out_byte  = bytes_reg[0];
    assign status    = status_reg;
    assign last      = (cnt_reg == 2'd1);

    // load a fresh bundle or shift out the sent beat
    always_comb
    begin
        cnt_next    = cnt_reg;
        bytes_next  = bytes_reg;
        status_next = status_reg;
        if (load)
        begin
            cnt_next    = bundle.cnt;
            bytes_next  = bundle.bytes;
            status_next = bundle.status;
        end
        else if (take)
        begin
            cnt_next   = cnt_reg - 2'd1;
            bytes_next = {8'h00, bytes_reg[2:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        status_reg <= status_next;
    end

    // a new bundle never overwrites beats still pending
    `ASSERT_CLK(a_load_no_overwrite, !load || can_load, "bundle overwritten")
    // markers are always a single final beat
    `ASSERT_CLK(a_marker_single, !(out_valid && status_reg != ST_DATA) || last, "marker not last")

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Decodes a JSON string body into UTF-8, one raw byte per input beat,
// starting after the opening quote. Plain and single escaped characters give
// one result beat each; a \uXXXX escape that encodes to two or three bytes
// holds the input until its bytes have gone, since the output shift register
// sends one result beat per cycle while out_stall is low. Backslash, 'u' and
// the first three hex digits give no result. Each input byte is registered in
// the skid input register and its result in the output shift register. End
// and error markers carry out_byte zero and return the parser to text mode.
// The input stall is registered: it comes straight from a skid entry flop.
// depends on jsu_pkg, jsu_skid, jsu_decode, jsu_emit and assert_macros.svh
`include "assert_macros.svh"
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       last
);
    import jsu_pkg::*;

    logic    a_valid;
    logic [7:0] a_byte;
    logic    a_take;
    logic    can_load;
    logic    plain_mode;
    state_t  state_reg, state_next, state_dec;
    bundle_t bundle;

    // input register with skid
    jsu_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .a_valid  (a_valid),
        .a_byte   (a_byte),
        .a_take   (a_take)
    );

    // decode the held byte against the parser state
    jsu_decode u_decode (
        .in_byte   (a_byte),
        .state_cur (state_reg),
        .state_nxt (state_dec),
        .res       (bundle)
    );

    assign a_take     = a_valid && can_load;
    assign state_next = a_take ? state_dec : state_reg;
    assign plain_mode = (state_reg.mode == MODE_TEXT) || (state_reg.mode == MODE_ESC);

    // parser state advances once per decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= MODE_TEXT;
            state_reg.accum <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result beats
    jsu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (a_take),
        .bundle    (bundle),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

    // accumulator is clear outside the hex digit modes
    `ASSERT_CLK(a_accum_clear, !plain_mode || state_reg.accum == '0, "stale accumulator")

endmodule
